FILE: hdl/vrt_pkg.sv
// Shared types and constants for the voxel ray traversal block.
// No dependencies; used by vrt_divider and voxel_ray_traversal_top.
package vrt_pkg;

   localparam int START_W = 24;
   localparam int DIR_W   = 16;
   localparam int BLOCK_W = 17;
   localparam int DIST_W  = 32;
   localparam int FACE_W  = 3;
   localparam int COUNT_W = 7;
   localparam int NUM_AX  = 3;

   // Distance has 16 fraction bits and direction 14, so 1/|dir| is 2^30 / |dir|.
   localparam int RECIP_SHIFT = 30;

   localparam int DVD_W = 32;
   localparam int DVS_W = 16;

   localparam logic [DIST_W-1:0] DIST_SAT  = '1;
   localparam logic [DVD_W-1:0]  RECIP_ONE = DVD_W'(64'd1 << RECIP_SHIFT);

   localparam logic [COUNT_W-1:0] STEP_COUNT_RESET = 7'd16;

   localparam logic [FACE_W-1:0] FACE_ZM = 3'd0;
   localparam logic [FACE_W-1:0] FACE_XM = 3'd1;
   localparam logic [FACE_W-1:0] FACE_ZP = 3'd2;
   localparam logic [FACE_W-1:0] FACE_XP = 3'd3;
   localparam logic [FACE_W-1:0] FACE_YP = 3'd4;
   localparam logic [FACE_W-1:0] FACE_YM = 3'd5;

   typedef logic signed [BLOCK_W-1:0] block_type;
   typedef logic [DIST_W-1:0] dist_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: hdl/voxel_ray_traversal_top.sv
// Top level of the voxel ray traversal block: set-up, divide sequencer and stepper.
// Depends on vrt_pkg and instantiates vrt_divider.
//
// One request beat carries a ray (start with POS_FRAC_BITS fraction bits, direction
// with 14 fraction bits). The block rounds the start to block coordinates, then runs
// six divisions on one shared two-bits-per-cycle divider (spacing and first boundary
// per axis). Each division is issued in S_DIV, runs in the divider and has its quotient
// collected in S_WAIT. An axis with zero direction skips its two divisions. The block
// then emits one response beat per face crossing, one per cycle while rsp_ready is high,
// step_count beats in all (0 is taken as 1, values above MAX_STEPS as MAX_STEPS). The
// next ray is taken only once the final beat has been emitted, and response stalls
// delay that. req_ready is high only while no ray is in work; the final beat may still
// wait in the output register while the next ray is taken. A null direction gives a
// single beat with error and last set. The step_count register is written through the
// csr_ port and should be changed only while the block is idle.
module voxel_ray_traversal_top #(
   parameter int MAX_STEPS     = 64,
   parameter int POS_FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [vrt_pkg::COUNT_W-1:0]    csr_step_count,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [vrt_pkg::START_W-1:0] req_start_x,
   input  logic signed [vrt_pkg::START_W-1:0] req_start_y,
   input  logic signed [vrt_pkg::START_W-1:0] req_start_z,
   input  logic signed [vrt_pkg::DIR_W-1:0]   req_dir_x,
   input  logic signed [vrt_pkg::DIR_W-1:0]   req_dir_y,
   input  logic signed [vrt_pkg::DIR_W-1:0]   req_dir_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [vrt_pkg::BLOCK_W-1:0] rsp_block_x,
   output logic signed [vrt_pkg::BLOCK_W-1:0] rsp_block_y,
   output logic signed [vrt_pkg::BLOCK_W-1:0] rsp_block_z,
   output logic [vrt_pkg::DIST_W-1:0]     rsp_distance,
   output logic [vrt_pkg::FACE_W-1:0]     rsp_face,
   output logic                           rsp_last,
   output logic                           rsp_error
);

   localparam int CALC_W   = vrt_pkg::START_W + 2;
   localparam int BND_SH   = vrt_pkg::RECIP_SHIFT - POS_FRAC_BITS;
   localparam int NUM_W    = POS_FRAC_BITS + 1;
   localparam logic [vrt_pkg::COUNT_W-1:0] MAX_CNT = vrt_pkg::COUNT_W'(MAX_STEPS);
   localparam logic signed [CALC_W-1:0] HALF = CALC_W'(64'd1 << (POS_FRAC_BITS - 1));

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_STEP  = 3'd3;
   localparam logic [2:0] S_NULL  = 3'd4;
   localparam logic [2:0] LAST_OP = 3'd5;

   // Per-axis inputs as arrays for the set-up loop.
   logic signed [vrt_pkg::START_W-1:0] start_a [vrt_pkg::NUM_AX];
   logic signed [vrt_pkg::DIR_W-1:0]   dir_a   [vrt_pkg::NUM_AX];

   // Set-up results, combinational from the request beat.
   logic signed [CALC_W-1:0]        s_c, abs_c, rnd_c, blk_c, num_c;
   logic [NUM_W-1:0]                numc_c [vrt_pkg::NUM_AX];
   vrt_pkg::block_type              blk0_c [vrt_pkg::NUM_AX];
   logic [vrt_pkg::DVS_W-1:0]       mag_c  [vrt_pkg::NUM_AX];

   // Per-ray state.
   logic [2:0]                      state_ff, state_in;
   logic [2:0]                      op_ff, op_in;
   logic [vrt_pkg::COUNT_W-1:0]     step_count_ff, step_count_in;
   logic [vrt_pkg::COUNT_W-1:0]     limit_ff, limit_in;
   logic [vrt_pkg::COUNT_W-1:0]     steps_done_ff, steps_done_in;
   logic [vrt_pkg::NUM_AX-1:0]      nz_ff, nz_in;
   logic [vrt_pkg::NUM_AX-1:0]      neg_ff, neg_in;
   vrt_pkg::block_type              block_ff [vrt_pkg::NUM_AX];
   vrt_pkg::block_type              block_in [vrt_pkg::NUM_AX];
   logic [NUM_W-1:0]                num_ff   [vrt_pkg::NUM_AX];
   logic [NUM_W-1:0]                num_in   [vrt_pkg::NUM_AX];
   logic [vrt_pkg::DVS_W-1:0]       mag_ff   [vrt_pkg::NUM_AX];
   logic [vrt_pkg::DVS_W-1:0]       mag_in   [vrt_pkg::NUM_AX];
   vrt_pkg::dist_type               bound_ff [vrt_pkg::NUM_AX];
   vrt_pkg::dist_type               bound_in [vrt_pkg::NUM_AX];
   vrt_pkg::dist_type               space_ff [vrt_pkg::NUM_AX];
   vrt_pkg::dist_type               space_in [vrt_pkg::NUM_AX];

   // Output register.
   logic                            rsp_valid_ff, rsp_valid_in;
   vrt_pkg::block_type              out_blk_ff [vrt_pkg::NUM_AX];
   vrt_pkg::block_type              out_blk_in [vrt_pkg::NUM_AX];
   vrt_pkg::dist_type               out_dist_ff, out_dist_in;
   logic [vrt_pkg::FACE_W-1:0]      out_face_ff, out_face_in;
   logic                            out_last_ff, out_last_in;
   logic                            out_err_ff, out_err_in;

   vrt_pkg::div_req_type            div_req;
   vrt_pkg::div_rsp_type            div_rsp;

   // Step datapath.
   logic [1:0]                      best;
   logic                            found;
   logic [1:0]                      op_axis;
   logic                            slot_free;
   logic [vrt_pkg::DIST_W:0]        sum;
   logic                            accept;
   logic                            is_last;

   assign start_a[0] = req_start_x;
   assign start_a[1] = req_start_y;
   assign start_a[2] = req_start_z;
   assign dir_a[0]   = req_dir_x;
   assign dir_a[1]   = req_dir_y;
   assign dir_a[2]   = req_dir_z;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign op_axis   = op_ff[2:1];

   // Rounding half away from zero and the distance to the first boundary, in
   // start units, for each axis.
   always_comb begin
      s_c   = '0;
      abs_c = '0;
      rnd_c = '0;
      blk_c = '0;
      num_c = '0;
      for (int a = 0; a < vrt_pkg::NUM_AX; a++) begin
         s_c   = CALC_W'(start_a[a]);
         abs_c = s_c[CALC_W-1] ? -s_c : s_c;
         rnd_c = (abs_c + HALF) >>> POS_FRAC_BITS;
         blk_c = s_c[CALC_W-1] ? -rnd_c : rnd_c;
         if (dir_a[a][vrt_pkg::DIR_W-1])
            num_c = s_c - (blk_c <<< POS_FRAC_BITS) + HALF;
         else
            num_c = (blk_c <<< POS_FRAC_BITS) + HALF - s_c;
         numc_c[a] = num_c[CALC_W-1] ? '0 : num_c[NUM_W-1:0];
         blk0_c[a] = blk_c[vrt_pkg::BLOCK_W-1:0];
         mag_c[a]  = dir_a[a][vrt_pkg::DIR_W-1] ? vrt_pkg::DVS_W'(-dir_a[a])
                                               : vrt_pkg::DVS_W'(dir_a[a]);
      end
   end

   // Axis choice: smallest boundary among axes that move; ties go to X, then Y, then Z.
   always_comb begin
      best  = 2'd0;
      found = 1'b0;
      for (int a = 0; a < vrt_pkg::NUM_AX; a++) begin
         if (nz_ff[a] && (!found || bound_ff[a] < bound_ff[best])) begin
            best  = 2'(a);
            found = 1'b1;
         end
      end
      sum = {1'b0, bound_ff[best]} + {1'b0, space_ff[best]};
   end

   assign is_last = (steps_done_ff + 1'b1) == limit_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      step_count_in = step_count_ff;
      limit_in      = limit_ff;
      steps_done_in = steps_done_ff;
      nz_in         = nz_ff;
      neg_in        = neg_ff;
      block_in      = block_ff;
      num_in        = num_ff;
      mag_in        = mag_ff;
      bound_in      = bound_ff;
      space_in      = space_ff;
      out_blk_in    = out_blk_ff;
      out_dist_in   = out_dist_ff;
      out_face_in   = out_face_ff;
      out_last_in   = out_last_ff;
      out_err_in    = out_err_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;

      div_req.start    = 1'b0;
      div_req.divisor  = mag_ff[op_axis];
      div_req.dividend = op_ff[0] ? (vrt_pkg::DVD_W'(num_ff[op_axis]) << BND_SH)
                                  : vrt_pkg::RECIP_ONE;

      if (csr_valid && csr_ready)
         step_count_in = csr_step_count;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               for (int a = 0; a < vrt_pkg::NUM_AX; a++) begin
                  nz_in[a]    = (dir_a[a] != '0);
                  neg_in[a]   = dir_a[a][vrt_pkg::DIR_W-1];
                  block_in[a] = blk0_c[a];
                  num_in[a]   = numc_c[a];
                  mag_in[a]   = mag_c[a];
               end
               if (step_count_ff == '0)
                  limit_in = vrt_pkg::COUNT_W'(1);
               else if (step_count_ff > MAX_CNT)
                  limit_in = MAX_CNT;
               else
                  limit_in = step_count_ff;
               steps_done_in = '0;
               op_in         = '0;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (!nz_ff[op_axis]) begin
               // A still axis never steps: both distances are saturated.
               if (op_ff[0])
                  bound_in[op_axis] = vrt_pkg::DIST_SAT;
               else
                  space_in[op_axis] = vrt_pkg::DIST_SAT;
               if (op_ff == LAST_OP)
                  state_in = (nz_ff != '0) ? S_STEP : S_NULL;
               else
                  op_in = op_ff + 1'b1;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_WAIT;
            end
         end
         S_WAIT: begin
            if (div_rsp.done) begin
               if (op_ff[0])
                  bound_in[op_axis] = div_rsp.quotient;
               else
                  space_in[op_axis] = div_rsp.quotient;
               if (op_ff == LAST_OP) begin
                  state_in = S_STEP;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_STEP: begin
            if (slot_free) begin
               bound_in[best] = sum[vrt_pkg::DIST_W] ? vrt_pkg::DIST_SAT
                                                     : sum[vrt_pkg::DIST_W-1:0];
               block_in[best] = neg_ff[best] ? block_ff[best] - 1'b1
                                             : block_ff[best] + 1'b1;
               out_blk_in     = block_in;
               out_dist_in    = bound_ff[best];
               case (best)
                  2'd0:    out_face_in = neg_ff[0] ? vrt_pkg::FACE_XM : vrt_pkg::FACE_XP;
                  2'd1:    out_face_in = neg_ff[1] ? vrt_pkg::FACE_YM : vrt_pkg::FACE_YP;
                  default: out_face_in = neg_ff[2] ? vrt_pkg::FACE_ZM : vrt_pkg::FACE_ZP;
               endcase
               out_last_in   = is_last;
               out_err_in    = 1'b0;
               rsp_valid_in  = 1'b1;
               steps_done_in = steps_done_ff + 1'b1;
               if (is_last)
                  state_in = S_IDLE;
            end
         end
         S_NULL: begin
            if (slot_free) begin
               out_blk_in   = block_ff;
               out_dist_in  = '0;
               out_face_in  = vrt_pkg::FACE_ZM;
               out_last_in  = 1'b1;
               out_err_in   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= '0;
         step_count_ff <= vrt_pkg::STEP_COUNT_RESET;
         limit_ff      <= vrt_pkg::COUNT_W'(1);
         steps_done_ff <= '0;
         nz_ff         <= '0;
         neg_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         step_count_ff <= step_count_in;
         limit_ff      <= limit_in;
         steps_done_ff <= steps_done_in;
         nz_ff         <= nz_in;
         neg_ff        <= neg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      block_ff    <= block_in;
      num_ff      <= num_in;
      mag_ff      <= mag_in;
      bound_ff    <= bound_in;
      space_ff    <= space_in;
      out_blk_ff  <= out_blk_in;
      out_dist_ff <= out_dist_in;
      out_face_ff <= out_face_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   vrt_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_block_x = out_blk_ff[0];
   assign rsp_block_y = out_blk_ff[1];
   assign rsp_block_z = out_blk_ff[2];
   assign rsp_distance = out_dist_ff;
   assign rsp_face    = out_face_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_error   = out_err_ff;

   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_IDLE) |-> !div_rsp.busy)
      else $error("divider busy while block idle");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && out_err_ff) |-> out_last_ff)
      else $error("error beat not marked last");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_STEP) |-> (steps_done_ff < limit_ff && nz_ff != '0))
      else $error("stepper ran past its limit");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_WAIT) |-> nz_ff[op_axis])
      else $error("division issued for a still axis");

endmodule

FILE: hdl/vrt_divider.sv
// Shared unsigned restoring divider, two quotient bits per cycle.
// Depends on vrt_pkg for widths and the request/response structs.
module vrt_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  vrt_pkg::div_req_type div_req,
   output vrt_pkg::div_rsp_type div_rsp
);

   localparam int CYCLES = vrt_pkg::DVD_W / 2;
   localparam int CNT_W  = $clog2(CYCLES);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [vrt_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [vrt_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [vrt_pkg::DVD_W-1:0] quo_ff, quo_in;

   logic [vrt_pkg::DVS_W:0]   r1, r2;
   logic                      ge1, ge2;
   logic [vrt_pkg::DVS_W-1:0] rem1, rem2;
   logic [vrt_pkg::DVD_W-1:0] q1, q2;

   always_comb begin
      r1   = {rem_ff, quo_ff[vrt_pkg::DVD_W-1]};
      ge1  = (r1 >= {1'b0, dvs_ff});
      rem1 = ge1 ? vrt_pkg::DVS_W'(r1 - {1'b0, dvs_ff}) : vrt_pkg::DVS_W'(r1);
      q1   = {quo_ff[vrt_pkg::DVD_W-2:0], ge1};
      r2   = {rem1, q1[vrt_pkg::DVD_W-1]};
      ge2  = (r2 >= {1'b0, dvs_ff});
      rem2 = ge2 ? vrt_pkg::DVS_W'(r2 - {1'b0, dvs_ff}) : vrt_pkg::DVS_W'(r2);
      q2   = {q1[vrt_pkg::DVD_W-2:0], ge2};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = rem2;
         quo_in = q2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider reports done while busy");
   assert property (@(posedge clock) disable iff (reset)
                    (div_req.start && !busy_ff) |=> busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> dvs_ff != '0)
      else $error("divider running with zero divisor");

endmodule

FILE: tb/tb_voxel_ray_traversal_top.sv
// Self-checking testbench for voxel_ray_traversal_top: directed rays from a table, then
// random rays, each response beat compared with a built-in traversal predictor.
// Depends on vrt_pkg and the RTL of voxel_ray_traversal_top.
`timescale 1ns / 100ps

module tb_voxel_ray_traversal_top;

   localparam int CLOCK_HALF    = 1;
   localparam int WATCHDOG_MAX  = 20000;
   localparam int DRAIN_CYCLES  = 300;
   localparam int RANDOM_RAYS   = 480;
   localparam int AXIS_X        = 0;
   localparam int AXIS_Y        = 1;
   localparam int AXIS_Z        = 2;
   localparam int POS_FRAC      = 8;

   // One expected response beat.
   typedef struct {
      logic signed [vrt_pkg::BLOCK_W-1:0] bx, by, bz;
      logic [vrt_pkg::DIST_W-1:0]         dist_val;
      logic [vrt_pkg::FACE_W-1:0]         face;
      logic                               last, err;
   } crossing_type;

   // One ray, plus an optional typed-in first crossing for the easy rows.
   typedef struct {
      logic signed [vrt_pkg::START_W-1:0] sx, sy, sz;
      logic signed [vrt_pkg::DIR_W-1:0]   dx, dy, dz;
      bit                                 has_known;
      crossing_type                       known;
   } ray_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [vrt_pkg::COUNT_W-1:0] csr_step_count = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [vrt_pkg::START_W-1:0] req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic signed [vrt_pkg::DIR_W-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [vrt_pkg::BLOCK_W-1:0] rsp_block_x, rsp_block_y, rsp_block_z;
   logic [vrt_pkg::DIST_W-1:0] rsp_distance;
   logic [vrt_pkg::FACE_W-1:0] rsp_face;
   logic rsp_last, rsp_error;

   always #CLOCK_HALF clock = ~clock;

   voxel_ray_traversal_top uut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_step_count(csr_step_count),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_start_x), .req_start_y(req_start_y), .req_start_z(req_start_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_block_x(rsp_block_x), .rsp_block_y(rsp_block_y), .rsp_block_z(rsp_block_z),
      .rsp_distance(rsp_distance), .rsp_face(rsp_face),
      .rsp_last(rsp_last), .rsp_error(rsp_error)
   );

   // Predictor state: the register copy and the queue of crossings still owed.
   logic [vrt_pkg::COUNT_W-1:0] crossings_per_ray = vrt_pkg::STEP_COUNT_RESET;
   crossing_type       pending_crossings[$];
   int                 failures = 0;
   int                 idle_cycles = 0;
   bit                 hold_off = 1'b0;
   bit                 random_gaps = 1'b1;

   // Rounds a start coordinate to its block, half away from zero.
   function automatic longint round_start(longint s);
      longint half;
      half = 64'sd1 <<< (POS_FRAC - 1);
      if (s >= 0) return (s + half) >>> POS_FRAC;
      return -((-s + half) >>> POS_FRAC);
   endfunction

   function automatic logic [vrt_pkg::DIST_W-1:0] clamp_dist(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? vrt_pkg::DIST_SAT : v[vrt_pkg::DIST_W-1:0];
   endfunction

   // True when two crossings differ in any field.
   function automatic bit crossing_differs(crossing_type x, crossing_type y);
      return (x.bx !== y.bx) || (x.by !== y.by) || (x.bz !== y.bz)
             || (x.dist_val !== y.dist_val) || (x.face !== y.face)
             || (x.last !== y.last) || (x.err !== y.err);
   endfunction

   // Walks the ray through the grid and queues every crossing it will produce.
   task automatic predict_crossings(input ray_type r);
      longint            start[3], dir[3], blk, num;
      longint unsigned   mag;
      logic [vrt_pkg::DIST_W-1:0] boundary[3], spacing[3];
      logic signed [vrt_pkg::BLOCK_W-1:0] cell_at[3];
      int                sgn[3];
      int                total, best;
      bit                moving;
      crossing_type      c;
      start = '{longint'(r.sx), longint'(r.sy), longint'(r.sz)};
      dir   = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
      moving = 1'b0;
      for (int a = 0; a < vrt_pkg::NUM_AX; a++) begin
         blk = round_start(start[a]);
         cell_at[a] = vrt_pkg::BLOCK_W'(blk);
         if (dir[a] == 0) begin
            sgn[a] = 0;
            spacing[a] = vrt_pkg::DIST_SAT;
            boundary[a] = vrt_pkg::DIST_SAT;
         end else begin
            moving = 1'b1;
            sgn[a] = (dir[a] > 0) ? 1 : -1;
            mag = (dir[a] < 0) ? -dir[a] : dir[a];
            spacing[a] = clamp_dist((64'd1 << vrt_pkg::RECIP_SHIFT) / mag);
            if (dir[a] > 0) num = blk * (1 << POS_FRAC) + (1 << (POS_FRAC - 1)) - start[a];
            else num = start[a] - blk * (1 << POS_FRAC) + (1 << (POS_FRAC - 1));
            if (num < 0) num = 0;
            boundary[a] = clamp_dist((longint'(num) << (vrt_pkg::RECIP_SHIFT - POS_FRAC))
                                     / mag);
         end
      end
      if (!moving) begin
         c = '{cell_at[AXIS_X], cell_at[AXIS_Y], cell_at[AXIS_Z], '0, vrt_pkg::FACE_ZM,
               1'b1, 1'b1};
         pending_crossings.push_back(c);
         return;
      end
      total = crossings_per_ray;
      if (total == 0) total = 1;
      if (total > 64) total = 64;
      for (int k = 0; k < total; k++) begin
         best = -1;
         for (int a = 0; a < vrt_pkg::NUM_AX; a++)
            if (sgn[a] != 0 && (best < 0 || boundary[a] < boundary[best])) best = a;
         c.dist_val = boundary[best];
         boundary[best] = clamp_dist(longint'(boundary[best]) + longint'(spacing[best]));
         cell_at[best] = cell_at[best] + vrt_pkg::BLOCK_W'(sgn[best]);
         case (best)
            AXIS_X:  c.face = (sgn[best] > 0) ? vrt_pkg::FACE_XP : vrt_pkg::FACE_XM;
            AXIS_Y:  c.face = (sgn[best] > 0) ? vrt_pkg::FACE_YP : vrt_pkg::FACE_YM;
            default: c.face = (sgn[best] > 0) ? vrt_pkg::FACE_ZP : vrt_pkg::FACE_ZM;
         endcase
         c.bx = cell_at[AXIS_X];
         c.by = cell_at[AXIS_Y];
         c.bz = cell_at[AXIS_Z];
         c.last = (k + 1 == total);
         c.err = 1'b0;
         pending_crossings.push_back(c);
      end
   endtask

   task automatic wait_cycles(input int n);
      repeat (n) @(posedge clock);
   endtask

   // Writes the step count and keeps the predictor's copy in step.
   task automatic write_step_count(input logic [vrt_pkg::COUNT_W-1:0] value);
      csr_step_count <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      crossings_per_ray = value;
   endtask

   // Offers one ray and returns once the request beat has been accepted. Valid drops
   // only for a gap, so back-to-back rays keep it high.
   task automatic send_ray(input ray_type r);
      int gap;
      gap = random_gaps ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         wait_cycles(gap);
      end
      req_start_x <= r.sx; req_start_y <= r.sy; req_start_z <= r.sz;
      req_dir_x <= r.dx; req_dir_y <= r.dy; req_dir_z <= r.dz;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_crossings(r);
   endtask

   // Lets the queue empty, then waits out any set-up work before the next write.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_crossings.size() != 0) @(posedge clock);
      wait_cycles(150);
   endtask

   function automatic ray_type make_ray(longint sx, longint sy, longint sz,
                                        int dx, int dy, int dz);
      ray_type r;
      r.sx = vrt_pkg::START_W'(sx); r.sy = vrt_pkg::START_W'(sy);
      r.sz = vrt_pkg::START_W'(sz);
      r.dx = vrt_pkg::DIR_W'(dx);   r.dy = vrt_pkg::DIR_W'(dy);
      r.dz = vrt_pkg::DIR_W'(dz);
      r.has_known = 1'b0;
      r.known = '{'0, '0, '0, '0, '0, 1'b0, 1'b0};
      return r;
   endfunction

   // Random start: mostly small values, sometimes full range.
   function automatic longint random_start();
      if ($urandom_range(0, 3) == 0) return longint'($signed(24'($urandom)));
      return longint'($signed(12'($urandom)));
   endfunction

   // Random direction: zero components and extremes turn up often.
   function automatic int random_dir();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return -32768;
         2: return 32767;
         3: return $urandom_range(0, 1) ? 1 : -1;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   // Response side: random stalls per beat, checks against the oldest crossing.
   initial begin : response_side
      crossing_type want;
      int           stall;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
         if (hold_off || stall != 0) begin
            rsp_ready <= 1'b0;
            while (hold_off) @(posedge clock);
            wait_cycles(stall);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_crossings.size() == 0) begin
            $error("response beat with nothing expected");
            failures++;
         end else begin
            want = pending_crossings.pop_front();
            if (rsp_block_x !== want.bx) begin
               $error("block_x expected %0d got %0d", want.bx, rsp_block_x); failures++;
            end
            if (rsp_block_y !== want.by) begin
               $error("block_y expected %0d got %0d", want.by, rsp_block_y); failures++;
            end
            if (rsp_block_z !== want.bz) begin
               $error("block_z expected %0d got %0d", want.bz, rsp_block_z); failures++;
            end
            if (rsp_distance !== want.dist_val) begin
               $error("distance expected %0h got %0h", want.dist_val, rsp_distance);
               failures++;
            end
            if (rsp_face !== want.face) begin
               $error("face expected %0d got %0d", want.face, rsp_face); failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %0b got %0b", want.last, rsp_last); failures++;
            end
            if (rsp_error !== want.err) begin
               $error("error expected %0b got %0b", want.err, rsp_error); failures++;
            end
         end
      end
   end

   // The watchdog counts cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Directed rays. The null-direction rows have their only beat typed in.
   ray_type directed[$];

   initial begin : stimulus
      ray_type r;
      logic [vrt_pkg::COUNT_W-1:0] settings[5] = '{7'd1, 7'd64, 7'd0, 7'd100, 7'd5};
      directed.push_back(make_ray(0, 0, 0, 0, 0, 0));
      directed.push_back(make_ray(-8388608, 8388607, 128, 0, 0, 0));
      directed.push_back(make_ray(-128, -384, 127, 0, 0, 0));
      directed.push_back(make_ray(0, 0, 0, 16384, 0, 0));
      directed.push_back(make_ray(0, 0, 0, -16384, 0, 0));
      directed.push_back(make_ray(0, 0, 0, 0, 16384, 0));
      directed.push_back(make_ray(0, 0, 0, 0, -16384, 0));
      directed.push_back(make_ray(0, 0, 0, 0, 0, 16384));
      directed.push_back(make_ray(0, 0, 0, 0, 0, -16384));
      // Equal distances on all axes: X wins, then Y, then Z.
      directed.push_back(make_ray(0, 0, 0, 16384, 16384, 16384));
      directed.push_back(make_ray(0, 0, 0, 1, 1, 1));
      directed.push_back(make_ray(0, 0, 0, 32767, -32768, 1));
      directed.push_back(make_ray(128, -128, 127, -32768, 32767, -1));
      // Rays that start at the extremes of the start range, where block coordinates are largest.
      directed.push_back(make_ray(8388607, 8388607, 8388607, 32767, 32767, 32767));
      directed.push_back(make_ray(-8388608, -8388608, -8388608, -32768, -32768, -32768));
      directed.push_back(make_ray(-8388608, 0, 8388607, 1, 0, -1));
      directed.push_back(make_ray(384, -640, 1000, 12000, -7000, 300));
      directed[0].has_known = 1'b1;
      directed[0].known = '{17'sd0, 17'sd0, 17'sd0, '0, vrt_pkg::FACE_ZM, 1'b1, 1'b1};
      directed[1].has_known = 1'b1;
      directed[1].known = '{-17'sd32768, 17'sd32768, 17'sd1, '0, vrt_pkg::FACE_ZM,
                            1'b1, 1'b1};
      directed[2].has_known = 1'b1;
      directed[2].known = '{-17'sd1, -17'sd2, 17'sd0, '0, vrt_pkg::FACE_ZM, 1'b1, 1'b1};

      wait_cycles(11);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value of the step count is in use for all directed rows.
      foreach (directed[i]) begin
         if (directed[i].has_known) begin
            predict_crossings(directed[i]);
            if (crossing_differs(pending_crossings[pending_crossings.size() - 1],
                                 directed[i].known)) begin
               $error("null-direction prediction differs from its typed-in beat");
               failures++;
            end
            void'(pending_crossings.pop_back());
         end
         send_ray(directed[i]);
      end

      // Random rays under a series of step counts, the extremes among them.
      for (int phase = 0; phase < 6; phase++) begin
         drain_block();
         write_step_count(phase < 5 ? settings[phase] : 7'($urandom_range(1, 20)));
         for (int i = 0; i < RANDOM_RAYS / 6; i++) begin
            random_gaps = !(phase == 2 && i < 20);
            r = make_ray(random_start(), random_start(), random_start(),
                         random_dir(), random_dir(), random_dir());
            // Most rays move; a fully null direction stays occasional.
            if (r.dx == 0 && r.dy == 0 && r.dz == 0 && $urandom_range(0, 3) != 0)
               r.dx = vrt_pkg::DIR_W'($urandom_range(1, 32767));
            // Long receiver hold-off while the sender keeps offering rays.
            if (phase == 1 && i == 4) hold_off = 1'b1;
            send_ray(r);
         end
      end
      drain_block();
      wait_cycles(DRAIN_CYCLES);
      if (failures == 0 && pending_crossings.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Releases the long hold-off after a fixed stretch of its own.
   initial begin : hold_off_timer
      wait (hold_off);
      wait_cycles(600);
      hold_off = 1'b0;
   end

endmodule
